// ----- sv/msss_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared store package
// Field widths, status codes, command codes and default sizes shared by the
// shared-store stack block.
// ----------------------------------------------------------------------------
`default_nettype none

package msss_pkg;

  // Request and response field widths.
  localparam int CMD_W    = 1;
  localparam int DATA_W   = 32;
  localparam int SN_W     = 3;
  localparam int STATUS_W = 2;

  // Default sizes.
  localparam int NUM_STACKS_DEF  = 8;
  localparam int STORE_DEPTH_DEF = 256;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ----- sv/msss_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read; the read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/multi_stack_shared_store_top.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared store
// NUM_STACKS linked stacks that share one store of STORE_DEPTH data words,
// with unused entries kept on a free list.
// ----------------------------------------------------------------------------
// Each request is handled on its own. A push, and any request that fails
// (store full, empty stack, or a stack number that is not present), goes from
// ST_IDLE to ST_LOOK, which puts its result in the output register and frees
// the input again. A successful pop goes on from ST_LOOK to ST_POP, which
// registers its result. No new request is taken before the last one is
// through. ST_POP is there because of two dependent
// synchronous memory reads: the stack-top RAM is read at acceptance, and a pop
// can only address the link and data RAMs once the top index is back. A result
// that waits in the output register holds the next request in flight until it
// is taken, while a new request can be accepted as soon as the previous one
// finished.
// Unused entries are tracked as an explicit free chain plus a high-water mark
// of entries never handed out, so no clearing pass is needed after reset.
`default_nettype none

module multi_stack_shared_store_top #(
  parameter int NUM_STACKS  = msss_pkg::NUM_STACKS_DEF,
  parameter int STORE_DEPTH = msss_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Request channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic        [msss_pkg::CMD_W-1:0]    command_i,
  input  wire logic signed [msss_pkg::DATA_W-1:0]   value_i,
  input  wire logic        [msss_pkg::SN_W-1:0]     stack_number_i,
  // Response channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic             [msss_pkg::STATUS_W-1:0] status_o,
  output logic signed      [msss_pkg::DATA_W-1:0]   popped_value_o
);

  import msss_pkg::*;

  // Index widths: IW holds every entry index plus the null code.
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IW = $clog2(STORE_DEPTH + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(STORE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [DATA_W-1:0]     popped_q, popped_d;
  logic [IW-1:0]         free_head_q, free_head_d;
  logic [IW-1:0]         hwm_q, hwm_d;
  logic [NUM_STACKS-1:0] top_vld_q, top_vld_d;

  // Captured request.
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [SN_W-1:0]   sn_q;

  // RAM ports.
  logic              tops_re, tops_we;
  logic [SW-1:0]     tops_raddr;
  logic [IW-1:0]     tops_wdata, tops_rdata;
  logic              link_re, link_we;
  logic [AW-1:0]     link_raddr, link_waddr;
  logic [IW-1:0]     link_wdata, link_rdata;
  logic              data_re, data_we;
  logic [AW-1:0]     data_raddr;
  logic [DATA_W-1:0] data_rdata;

  // Derived control.
  logic          accept;
  logic          finish_ok;
  logic [SW+2:0] sn_in_ext, sn_q_ext;
  logic [SW-1:0] sn_addr;
  logic          sn_ok;
  logic [IW-1:0] top_eff;
  logic          top_null;
  logic          head_null;
  logic          store_full;
  logic [AW-1:0] push_idx;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign accept         = in_valid_i && in_ready_o;
  assign finish_ok      = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;

  // Stack number as a top-RAM address, and its range check.
  assign sn_in_ext  = (SW + 3)'(stack_number_i);
  assign sn_q_ext   = (SW + 3)'(sn_q);
  assign tops_raddr = sn_in_ext[SW-1:0];
  assign sn_addr    = sn_q_ext[SW-1:0];
  assign sn_ok      = (32'(sn_q) < NUM_STACKS);

  // A stack top that was never written reads as null.
  assign top_eff  = top_vld_q[sn_addr] ? tops_rdata : NULL_IDX;
  assign top_null = (top_eff >= NULL_IDX);

  // Free entries: the explicit chain first, then the never-used range.
  assign head_null  = (free_head_q >= NULL_IDX);
  assign store_full = head_null && (hwm_q >= NULL_IDX);
  assign push_idx   = head_null ? hwm_q[AW-1:0] : free_head_q[AW-1:0];

  // The top RAM is read as a request is accepted.
  assign tops_re = accept;

  // Sequencer and memory access control.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    popped_d    = popped_q;
    free_head_d = free_head_q;
    hwm_d       = hwm_q;
    top_vld_d   = top_vld_q;
    tops_we     = 1'b0;
    tops_wdata  = top_eff;
    link_re     = 1'b0;
    link_raddr  = free_head_q[AW-1:0];
    link_we     = 1'b0;
    link_waddr  = push_idx;
    link_wdata  = top_eff;
    data_re     = 1'b0;
    data_raddr  = top_eff[AW-1:0];
    data_we     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Fetch the free head's link alongside the stack top.
          link_re = 1'b1;
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        if (cmd_q == CMD_PUSH) begin
          if (finish_ok) begin
            out_valid_d = 1'b1;
            popped_d    = '0;
            state_d     = ST_IDLE;
            if (!sn_ok || store_full) begin
              status_d = STATUS_FULL;
            end else begin
              status_d  = STATUS_DONE;
              data_we   = 1'b1;
              link_we   = 1'b1;
              tops_we   = 1'b1;
              tops_wdata = IW'(push_idx);
              top_vld_d[sn_addr] = 1'b1;
              if (head_null) begin
                hwm_d = hwm_q + IW'(1);
              end else begin
                free_head_d = link_rdata;
              end
            end
          end
        end else if (!sn_ok || top_null) begin
          if (finish_ok) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_EMPTY;
            popped_d    = '0;
            state_d     = ST_IDLE;
          end
        end else begin
          // Read the top entry's link and word.
          link_re    = 1'b1;
          link_raddr = top_eff[AW-1:0];
          data_re    = 1'b1;
          state_d    = ST_POP;
        end
      end

      ST_POP: begin
        if (finish_ok) begin
          // Unlink the top and return its entry to the free chain.
          tops_we     = 1'b1;
          tops_wdata  = link_rdata;
          link_we     = 1'b1;
          link_waddr  = top_eff[AW-1:0];
          link_wdata  = free_head_q;
          free_head_d = top_eff;
          out_valid_d = 1'b1;
          status_d    = STATUS_DONE;
          popped_d    = data_rdata;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, free-list registers and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_DONE;
      popped_q    <= '0;
      free_head_q <= NULL_IDX;
      hwm_q       <= '0;
      top_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      popped_q    <= popped_d;
      free_head_q <= free_head_d;
      hwm_q       <= hwm_d;
      top_vld_q   <= top_vld_d;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      value_q <= value_i;
      sn_q    <= stack_number_i;
    end
  end

  // Stack tops, one index per stack.
  msss_ram #(
    .WIDTH(IW),
    .DEPTH(NUM_STACKS)
  ) u_tops_ram (
    .clk_i  (clk_i),
    .we_i   (tops_we),
    .waddr_i(sn_addr),
    .wdata_i(tops_wdata),
    .re_i   (tops_re),
    .raddr_i(tops_raddr),
    .rdata_o(tops_rdata)
  );

  // Links between entries, for stacks and the free chain alike.
  msss_ram #(
    .WIDTH(IW),
    .DEPTH(STORE_DEPTH)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  // Data words.
  msss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(push_idx),
    .wdata_i(value_q),
    .re_i   (data_re),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  // A response only appears when a request finishes.
  a_resp_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q != ST_IDLE))
    else $error("response raised without a request in flight");

  // The never-used range never runs past the store.
  a_hwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= NULL_IDX)
    else $error("high-water mark beyond store depth");

  // The free head is an entry or null, never beyond.
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NULL_IDX)
    else $error("free head out of range");

  // Failed requests return a zero word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_DONE) |-> (popped_q == '0))
    else $error("failed request returned a nonzero word");

  // Stores change only while a request is in flight and may finish.
  a_write_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_we || tops_we || data_we) |-> (state_q != ST_IDLE && finish_ok))
    else $error("store written outside request completion");

endmodule

`default_nettype wire

// ----- dv/msss_checker.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared store checker
// Watches the request and response channels of the shared-store stack block.
// Every accepted request is run through a local model of the stacks and the
// free list. Each accepted response is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msss_checker #(
  parameter int NUM_STACKS  = msss_pkg::NUM_STACKS_DEF,
  parameter int STORE_DEPTH = msss_pkg::STORE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request channel
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [msss_pkg::CMD_W-1:0]           command_i,
  input  logic signed [msss_pkg::DATA_W-1:0]   value_i,
  input  logic [msss_pkg::SN_W-1:0]            stack_number_i,
  // Response channel
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [msss_pkg::STATUS_W-1:0]        status_i,
  input  logic signed [msss_pkg::DATA_W-1:0]   popped_value_i,
  // Bookkeeping for the testbench top
  output int                                   error_count_o,
  output int                                   outstanding_o,
  output int                                   store_used_o,
  output int                                   responses_o,
  output int                                   pushes_done_o,
  output int                                   pops_done_o,
  output int                                   full_refused_o,
  output int                                   empty_pops_o
);

  import msss_pkg::*;

  // One index value past the last entry marks the end of a chain.
  localparam int IDX_W = $clog2(STORE_DEPTH + 1);
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(STORE_DEPTH);

  // Room for predictions that still wait for their response.
  localparam int PEND_DEPTH = 16;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    popped;
  } stack_resp_t;

  // Local copy of the block's state.
  logic [DATA_W-1:0] word_mem  [STORE_DEPTH];
  logic [IDX_W-1:0]  next_link [STORE_DEPTH];
  logic [IDX_W-1:0]  top_of    [NUM_STACKS];
  logic [IDX_W-1:0]  free_head;

  // Predicted responses in request order, kept in a ring.
  stack_resp_t pend_ring [PEND_DEPTH];
  int          pend_rd;
  int          pend_wr;
  int          pend_cnt;

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    error_count_o++;
    $display("[%0t] mismatch on %s: expected 'h%08h, got 'h%08h", $time, what,
             want, got);
  endtask

  // Apply one request to the local stacks and work out its response.
  task automatic apply_stack_request(input logic [CMD_W-1:0] cmd,
                                     input logic [DATA_W-1:0] val,
                                     input logic [SN_W-1:0] sn,
                                     output stack_resp_t resp);
    logic [IDX_W-1:0] idx;
    resp.status = STATUS_DONE;
    resp.popped = '0;
    if (cmd == CMD_PUSH) begin
      idx = free_head;
      if (int'(sn) >= NUM_STACKS || idx >= NULL_IDX) begin
        resp.status = STATUS_FULL;
        full_refused_o++;
      end else begin
        free_head      = next_link[idx];
        word_mem[idx]  = val;
        next_link[idx] = top_of[sn];
        top_of[sn]     = idx;
        store_used_o++;
        pushes_done_o++;
      end
    end else if (int'(sn) >= NUM_STACKS || top_of[sn] >= NULL_IDX) begin
      resp.status = STATUS_EMPTY;
      empty_pops_o++;
    end else begin
      idx            = top_of[sn];
      top_of[sn]     = next_link[idx];
      resp.popped    = word_mem[idx];
      next_link[idx] = free_head;
      free_head      = idx;
      store_used_o--;
      pops_done_o++;
    end
  endtask

  initial begin
    error_count_o = 0;
  end

  // Compare responses first, then predict for the request taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    stack_resp_t want_resp;
    stack_resp_t new_resp;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        word_mem[i]  = '0;
        next_link[i] = IDX_W'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
        top_of[s] = NULL_IDX;
      end
      free_head = '0;
      pend_rd   = 0;
      pend_wr   = 0;
      pend_cnt  = 0;
      outstanding_o  = 0;
      store_used_o   = 0;
      responses_o    = 0;
      pushes_done_o  = 0;
      pops_done_o    = 0;
      full_refused_o = 0;
      empty_pops_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        responses_o++;
        if (pend_cnt == 0) begin
          report_mismatch("response with no request pending", '0, popped_value_i);
        end else begin
          want_resp = pend_ring[pend_rd];
          pend_rd   = (pend_rd + 1) % PEND_DEPTH;
          pend_cnt--;
          if (status_i !== want_resp.status) begin
            report_mismatch("status", DATA_W'(want_resp.status), DATA_W'(status_i));
          end
          if (popped_value_i !== want_resp.popped) begin
            report_mismatch("popped_value", want_resp.popped, popped_value_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_stack_request(command_i, value_i, stack_number_i, new_resp);
        if (pend_cnt == PEND_DEPTH) begin
          report_mismatch("requests in flight", DATA_W'(PEND_DEPTH),
                          DATA_W'(pend_cnt + 1));
        end else begin
          pend_ring[pend_wr] = new_resp;
          pend_wr            = (pend_wr + 1) % PEND_DEPTH;
          pend_cnt++;
        end
      end
      outstanding_o = pend_cnt;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared store testbench
// Drives push and pop requests into the shared-store stack block: a short
// directed part, then random traffic that fills the store to the point of
// refusal and drains part of it again, with idle gaps on both channels and a
// long response stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import msss_pkg::*;

  localparam int NUM_STACKS  = NUM_STACKS_DEF;
  localparam int STORE_DEPTH = STORE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [CMD_W-1:0]           command_i;
  logic signed [DATA_W-1:0]   value_i;
  logic [SN_W-1:0]            stack_number_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [STATUS_W-1:0]        status_o;
  logic signed [DATA_W-1:0]   popped_value_o;

  int error_count;
  int outstanding;
  int store_used;
  int responses;
  int pushes_done;
  int pops_done;
  int full_refused;
  int empty_pops;

  // Control shared by the two sides; the stimulus sets it at falling edges and
  // the response side clears the hold request once it has picked it up.
  bit idle_on;
  bit hold_req;
  int cycle_count;

  multi_stack_shared_store_top #(
    .NUM_STACKS  (NUM_STACKS),
    .STORE_DEPTH (STORE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .stack_number_i (stack_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o)
  );

  msss_checker #(
    .NUM_STACKS  (NUM_STACKS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .stack_number_i (stack_number_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .popped_value_i (popped_value_o),
    .error_count_o  (error_count),
    .outstanding_o  (outstanding),
    .store_used_o   (store_used),
    .responses_o    (responses),
    .pushes_done_o  (pushes_done),
    .pops_done_o    (pops_done),
    .full_refused_o (full_refused),
    .empty_pops_o   (empty_pops)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run limit reached with %0d responses still due.", outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side: random stall bursts, plus one long hold-off on request.
  initial begin : response_side
    int  hold_left;
    int  stall_left;
    bit  next_ready;
    hold_left   = 0;
    stall_left  = 0;
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 4);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      @(negedge clk_i);
      out_ready_i <= next_ready;
    end
  end

  // Offer one request and wait until it is taken. Called and returns at a
  // falling edge; valid stays high so the next call can follow directly.
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [DATA_W-1:0] val,
                              input logic [SN_W-1:0] sn);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    value_i        <= val;
    stack_number_i <= sn;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random pushes and pops; push_pct sets the share of pushes.
  task automatic random_requests(input int count, input int push_pct);
    for (int n = 0; n < count; n++) begin
      send_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                   $urandom, SN_W'($urandom_range(0, NUM_STACKS - 1)));
    end
  endtask

  // Stop offering until every predicted response has been taken.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_PUSH;
    value_i        = '0;
    stack_number_i = '0;
    idle_on        = 1'b0;
    hold_req       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: pops from empty stacks, extreme values, LIFO order per stack.
    send_request(CMD_POP,  $urandom,     3'd0);
    send_request(CMD_POP,  $urandom,     3'd7);
    send_request(CMD_PUSH, 32'h7FFFFFFF, 3'd0);
    send_request(CMD_PUSH, 32'h80000000, 3'd7);
    send_request(CMD_PUSH, 32'h00000000, 3'd3);
    send_request(CMD_PUSH, 32'hFFFFFFFF, 3'd3);
    send_request(CMD_PUSH, 32'hAAAAAAAA, 3'd5);
    send_request(CMD_PUSH, 32'h55555555, 3'd5);
    send_request(CMD_PUSH, 32'h00000001, 3'd0);
    send_request(CMD_POP,  32'hFFFFFFFF, 3'd3);
    send_request(CMD_POP,  32'h00000000, 3'd3);
    send_request(CMD_POP,  $urandom,     3'd3);
    send_request(CMD_POP,  $urandom,     3'd0);
    send_request(CMD_POP,  $urandom,     3'd0);
    send_request(CMD_POP,  $urandom,     3'd7);
    send_request(CMD_POP,  $urandom,     3'd5);
    send_request(CMD_POP,  $urandom,     3'd5);
    send_request(CMD_POP,  $urandom,     3'd0);

    // Mixed traffic with idle gaps on both sides.
    idle_on = 1'b1;
    random_requests(30, 60);

    // Long response stall while requests keep coming, so the block backs up.
    hold_req = 1'b1;
    random_requests(30, 70);
    wait_for_drain();

    // Fill the whole store, then push into a full store.
    while (store_used < STORE_DEPTH) begin
      send_request(CMD_PUSH, $urandom, SN_W'($urandom_range(0, NUM_STACKS - 1)));
    end
    send_request(CMD_PUSH, 32'h7FFFFFFF, 3'd0);
    send_request(CMD_PUSH, 32'h80000000, 3'd7);
    send_request(CMD_PUSH, $urandom,     3'd4);
    random_requests(20, 50);

    // Pop a good part of the store back out.
    random_requests(80, 5);
    wait_for_drain();

    // Last stretch without idling.
    idle_on = 1'b0;
    random_requests(40, 40);

    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Covered %0d responses: %0d pushes, %0d pops with data, %0d full refusals,",
             responses, pushes_done, pops_done, full_refused);
    $display("%0d pops from empty stacks, a full store, a long stall and idle gaps.",
             empty_pops);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/msss_pkg.sv
sv/msss_ram.sv
sv/multi_stack_shared_store_top.sv
dv/msss_checker.sv
dv/tb_top.sv
